// File: design/local_interrupt_timer_unit_assert.svh
// Concurrent assertion macros for the local interrupt timer.
`ifndef LOCAL_INTERRUPT_TIMER_UNIT_ASSERT_SVH
`define LOCAL_INTERRUPT_TIMER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check that prop holds at every clock edge outside reset.
`define LIT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("local_interrupt_timer_unit: assertion failed");

// Check that cond at one edge implies prop at the next edge.
`define LIT_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("local_interrupt_timer_unit: assertion failed");

`else

`define LIT_ASSERT(label, clk, rst, prop)
`define LIT_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// File: design/lit_pkg.sv
`timescale 1ns / 1ps
package lit_pkg;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_WRITE = 2'd2
   } mode_type;

   localparam logic [11:0] OFF_SPURIOUS    = 12'h0F0;
   localparam logic [11:0] OFF_TIMER_ENTRY = 12'h320;
   localparam logic [11:0] OFF_INIT_COUNT  = 12'h380;
   localparam logic [11:0] OFF_CUR_COUNT   = 12'h390;
   localparam logic [11:0] OFF_DIVIDE      = 12'h3E0;

   localparam int SW_ENABLE_BIT = 8;
   localparam int MASK_BIT      = 16;
   localparam int PERIODIC_BIT  = 17;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_fire;
      logic [7:0]  irq_vector;
   } rsp_word_type;

endpackage

// File: design/local_interrupt_timer_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tuser: mode; tdata: reg_offset, write_data
// rsp      out  rsp_tvalid/rsp_tready  tdata: read_data, irq_fire, irq_vector
//
// One word per cycle in and out while rsp is not stalled; each word's result is registered.
// Timer state and the result are computed in a single pass from the request word
// into the result register; a one-word skid register backs the result register.
// req_tready drops only while the skid register holds a word (rsp stalled).
// Reset is synchronous, active high, and leaves the timer masked and disabled.
module local_interrupt_timer_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [1:0]                    req_tuser,  // mode
   input  logic [lit_pkg::REQ_DATA_W-1:0] req_tdata, // reg_offset, write_data, pad
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lit_pkg::RSP_DATA_W-1:0] rsp_tdata  // read_data, irq_fire, irq_vector, pad
);
   import lit_pkg::*;

   logic [8:0]   spurious_ff,  spurious_in;
   logic [7:0]   vector_ff,    vector_in;
   logic         mask_ff,      mask_in;
   logic         periodic_ff,  periodic_in;
   logic [3:0]   divide_ff,    divide_in;
   logic [31:0]  reload_ff,    reload_in;
   logic [31:0]  count_ff,     count_in;
   logic [6:0]   prescale_ff,  prescale_in;

   logic         out_valid_ff,  out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type out_word_ff,   out_word_in;
   rsp_word_type skid_word_ff,  skid_word_in;

   logic         accept;
   mode_type     mode;
   logic [11:0]  offset;
   logic [31:0]  wdata;
   logic [2:0]   div_shift;
   logic [6:0]   span_mask;
   logic [6:0]   prescale_next;
   rsp_word_type result;

   assign accept = req_tvalid && req_tready;
   assign mode   = mode_type'(req_tuser);
   assign offset = req_tdata[11:0];
   assign wdata  = req_tdata[43:12];

   assign div_shift     = 3'({divide_ff[3], divide_ff[1:0]} + 3'd1);
   assign span_mask     = 7'((8'd1 << div_shift) - 8'd1);
   assign prescale_next = 7'(prescale_ff + 7'd1) & span_mask;

   always_comb begin
      spurious_in = spurious_ff;
      vector_in   = vector_ff;
      mask_in     = mask_ff;
      periodic_in = periodic_ff;
      divide_in   = divide_ff;
      reload_in   = reload_ff;
      count_in    = count_ff;
      prescale_in = prescale_ff;
      result      = '0;
      if (accept) begin
         unique case (mode)
            MODE_TICK: begin
               prescale_in = prescale_next;
               if (prescale_next == 7'd0 && count_ff != 32'd0) begin
                  count_in = count_ff - 32'd1;
                  if (count_ff == 32'd1) begin
                     result.irq_fire   = !mask_ff && spurious_ff[SW_ENABLE_BIT];
                     result.irq_vector = result.irq_fire ? vector_ff : 8'd0;
                     if (periodic_ff) begin
                        count_in = reload_ff;
                     end
                  end
               end
            end
            MODE_READ: begin
               unique case (offset)
                  OFF_SPURIOUS:    result.read_data = {23'd0, spurious_ff};
                  OFF_TIMER_ENTRY: result.read_data = {14'd0, periodic_ff, mask_ff,
                                                       8'd0, vector_ff};
                  OFF_DIVIDE:      result.read_data = {28'd0, divide_ff};
                  OFF_INIT_COUNT:  result.read_data = reload_ff;
                  OFF_CUR_COUNT:   result.read_data = count_ff;
                  default:         result.read_data = 32'd0;
               endcase
            end
            MODE_WRITE: begin
               unique case (offset)
                  OFF_SPURIOUS: spurious_in = wdata[8:0];
                  OFF_TIMER_ENTRY: begin
                     vector_in   = wdata[7:0];
                     mask_in     = wdata[MASK_BIT];
                     periodic_in = wdata[PERIODIC_BIT];
                  end
                  OFF_DIVIDE: divide_in = wdata[3:0] & 4'hB;
                  OFF_INIT_COUNT: begin
                     reload_in = wdata;
                     count_in  = wdata;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   // result register with skid word behind it
   assign req_tready = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_word_in   = out_word_ff;
      skid_word_in  = skid_word_ff;
      if (rsp_tready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_word_in   = skid_word_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_word_in  = result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_word_in  = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spurious_ff   <= 9'h0FF;
         vector_ff     <= 8'd0;
         mask_ff       <= 1'b1;
         periodic_ff   <= 1'b0;
         divide_ff     <= 4'd0;
         reload_ff     <= 32'd0;
         count_ff      <= 32'd0;
         prescale_ff   <= 7'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         spurious_ff   <= spurious_in;
         vector_ff     <= vector_in;
         mask_ff       <= mask_in;
         periodic_ff   <= periodic_in;
         divide_ff     <= divide_in;
         reload_ff     <= reload_in;
         count_ff      <= count_in;
         prescale_ff   <= prescale_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_word_ff.irq_vector, out_word_ff.irq_fire,
                        out_word_ff.read_data};

`include "local_interrupt_timer_unit_assert.svh"

`LIT_ASSERT(a_skid_behind_out, clock, reset, !skid_valid_ff || out_valid_ff)
`LIT_ASSERT(a_vector_only_on_fire, clock, reset, !out_valid_ff || out_word_ff.irq_fire || out_word_ff.irq_vector == 8'd0)
`LIT_ASSERT(a_fire_no_read_data, clock, reset, !out_valid_ff || !out_word_ff.irq_fire || out_word_ff.read_data == 32'd0)
`LIT_ASSERT_NEXT(a_stopped_count_holds, clock, reset, count_ff == 32'd0 && !(accept && mode == MODE_WRITE), count_ff == 32'd0)

endmodule

// File: dv/tb_local_interrupt_timer_unit.sv
`timescale 1ns / 1ps
module tb_local_interrupt_timer_unit;
   import lit_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 500;
   localparam int HOLD_CYCLES = 60;
   localparam int IDLE_LIMIT  = 3000;
   localparam int SETTLE_CYCLES = 10;

   typedef struct {
      logic [31:0] read_data;
      logic        irq_fire;
      logic [7:0]  irq_vector;
   } timer_result_type;

   class timer_tracker;
      logic [8:0]    spurious;
      logic [7:0]    vector;
      logic          masked;
      logic          periodic;
      logic [3:0]    div_code;
      logic [31:0]   reload;
      logic [31:0]   count;
      logic [6:0]    prescale;
      timer_result_type pending_results[$];
      int errors;
      int ticks;
      int reads;
      int writes;
      int fires;
      int words_checked;

      function new();
         spurious = 9'h0FF;
         vector   = 8'd0;
         masked   = 1'b1;
         periodic = 1'b0;
         div_code = 4'd0;
         reload   = 32'd0;
         count    = 32'd0;
         prescale = 7'd0;
         errors = 0;
         ticks = 0;
         reads = 0;
         writes = 0;
         fires = 0;
         words_checked = 0;
      endfunction

      function logic tick_fires();
         logic [2:0] code;
         logic [2:0] shift;
         logic [7:0] span;
         logic       fire;
         code  = {div_code[3], div_code[1:0]};
         shift = code + 3'd1;
         span  = 8'd1 << shift;
         fire  = 1'b0;
         prescale = (prescale + 7'd1) & (span[6:0] - 7'd1);
         if (prescale == 7'd0 && count != 32'd0) begin
            count = count - 32'd1;
            if (count == 32'd0) begin
               fire = !masked && spurious[SW_ENABLE_BIT];
               if (periodic)
                  count = reload;
            end
         end
         return fire;
      endfunction

      function logic [31:0] read_register(logic [11:0] off);
         case (off)
            OFF_SPURIOUS:    return {23'd0, spurious};
            OFF_TIMER_ENTRY: return {14'd0, periodic, masked, 8'd0, vector};
            OFF_DIVIDE:      return {28'd0, div_code & 4'hB};
            OFF_INIT_COUNT:  return reload;
            OFF_CUR_COUNT:   return count;
            default:         return 32'd0;
         endcase
      endfunction

      function void write_register(logic [11:0] off, logic [31:0] data);
         case (off)
            OFF_SPURIOUS: spurious = data[8:0];
            OFF_TIMER_ENTRY: begin
               vector   = data[7:0];
               masked   = data[MASK_BIT];
               periodic = data[PERIODIC_BIT];
            end
            OFF_DIVIDE: div_code = data[3:0] & 4'hB;
            OFF_INIT_COUNT: begin
               reload = data;
               count  = data;
            end
            default: ;
         endcase
      endfunction

      function void take_request(logic [1:0] mode, logic [11:0] off, logic [31:0] data);
         timer_result_type r;
         r.read_data  = 32'd0;
         r.irq_fire   = 1'b0;
         r.irq_vector = 8'd0;
         case (mode)
            MODE_TICK: begin
               ticks++;
               if (tick_fires()) begin
                  r.irq_fire   = 1'b1;
                  r.irq_vector = vector;
                  fires++;
               end
            end
            MODE_READ: begin
               reads++;
               r.read_data = read_register(off);
            end
            MODE_WRITE: begin
               writes++;
               write_register(off, data);
            end
            default: ;
         endcase
         pending_results.push_back(r);
      endfunction

      function void flag_error(string what);
         errors++;
         if (errors <= 10)
            $display("%0t mismatch: %s", $realtime, what);
      endfunction

      function void match_result(logic [31:0] rd, logic fire, logic [7:0] vec);
         timer_result_type e;
         if (pending_results.size() == 0) begin
            flag_error($sformatf("unexpected word rd=%h fire=%b vec=%h", rd, fire, vec));
            return;
         end
         e = pending_results.pop_front();
         words_checked++;
         if (rd !== e.read_data)
            flag_error($sformatf("read_data exp %h got %h", e.read_data, rd));
         if (fire !== e.irq_fire)
            flag_error($sformatf("irq_fire exp %b got %b", e.irq_fire, fire));
         if (vec !== e.irq_vector)
            flag_error($sformatf("irq_vector exp %h got %h", e.irq_vector, vec));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [1:0]            req_tuser;   // mode
   logic [REQ_DATA_W-1:0] req_tdata;   // reg_offset, write_data, pad
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // read_data, irq_fire, irq_vector, pad

   timer_tracker tracker;
   int  items_sent;
   int  steady_left;
   bit  hold_request;
   int  holds_done;
   int  idle_cycles;

   local_interrupt_timer_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      tracker = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 2'd0;
      req_tdata = '0;
      hold_request = 1'b0;
      holds_done = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // sample both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            tracker.take_request(req_tuser, req_tdata[11:0], req_tdata[43:12]);
         if (rsp_tvalid && rsp_tready)
            tracker.match_result(rsp_tdata[31:0], rsp_tdata[32], rsp_tdata[40:33]);
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // receiver: ready runs, random stalls, and one long hold-off on request
   initial begin
      int len;
      int r;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         if (hold_request) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            holds_done++;
         end
         r = $urandom_range(0, 99);
         len = (r < 20) ? $urandom_range(30, 80) : $urandom_range(1, 6);
         repeat (len) begin
            @(negedge clock);
            rsp_tready <= 1'b1;
         end
         len = pick_gap();
         repeat (len) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
      end
   end

   task automatic send_word(input logic [1:0] mode, input logic [11:0] off,
                            input logic [31:0] data);
      int gap;
      if (steady_left > 0) begin
         gap = 0;
         steady_left--;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 49) == 0)
            steady_left = $urandom_range(20, 50);
      end
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'd0, data, off};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   function automatic logic [11:0] pick_offset();
      logic [11:0] known[5];
      known = '{OFF_SPURIOUS, OFF_TIMER_ENTRY, OFF_DIVIDE, OFF_INIT_COUNT, OFF_CUR_COUNT};
      if ($urandom_range(0, 9) < 8)
         return known[$urandom_range(0, 4)];
      return 12'($urandom_range(0, 4095));
   endfunction

   function automatic logic [31:0] pick_divide();
      logic [31:0] d;
      logic [2:0]  c;
      int r;
      d = $urandom;
      r = $urandom_range(0, 9);
      if (r < 4)      c = 3'd7;
      else if (r < 6) c = 3'd0;
      else if (r < 8) c = 3'($urandom_range(1, 2));
      else            c = 3'($urandom_range(0, 7));
      d[3]   = c[2];
      d[1:0] = c[1:0];
      return d;
   endfunction

   task automatic noise_word();
      send_word(2'($urandom_range(0, 3)), pick_offset(), $urandom);
   endtask

   task automatic program_and_run();
      logic [31:0] d;
      int n;
      int r;
      d = $urandom;
      d[SW_ENABLE_BIT] = ($urandom_range(0, 9) != 0);
      send_word(MODE_WRITE, OFF_SPURIOUS, d);
      d = $urandom;
      d[MASK_BIT]     = ($urandom_range(0, 4) == 0);
      d[PERIODIC_BIT] = $urandom_range(0, 1);
      send_word(MODE_WRITE, OFF_TIMER_ENTRY, d);
      send_word(MODE_WRITE, OFF_DIVIDE, pick_divide());
      r = $urandom_range(0, 19);
      if (r == 0)      d = 32'd0;
      else if (r == 1) d = $urandom;
      else             d = $urandom_range(1, 6);
      send_word(MODE_WRITE, OFF_INIT_COUNT, d);
      n = $urandom_range(10, 50);
      repeat (n) begin
         r = $urandom_range(0, 19);
         if (r == 0)      send_word(MODE_READ, pick_offset(), $urandom);
         else if (r == 1) send_word(MODE_WRITE, OFF_DIVIDE, pick_divide());
         else if (r == 2) noise_word();
         else             send_word(MODE_TICK, 12'($urandom_range(0, 4095)), $urandom);
      end
   endtask

   initial begin
      bit held;
      bit paused;
      items_sent = 0;
      steady_left = 0;
      held = 1'b0;
      paused = 1'b0;
      wait (!reset);

      send_word(MODE_READ, OFF_SPURIOUS, 32'd0);
      send_word(MODE_READ, OFF_TIMER_ENTRY, 32'd0);
      send_word(MODE_READ, OFF_DIVIDE, 32'd0);
      send_word(MODE_READ, OFF_INIT_COUNT, 32'd0);
      send_word(MODE_READ, OFF_CUR_COUNT, 32'd0);
      send_word(MODE_READ, 12'hFFF, 32'hFFFF_FFFF);
      send_word(MODE_READ, 12'h321, 32'd0);
      send_word(MODE_UNUSED, OFF_SPURIOUS, 32'hFFFF_FFFF);
      send_word(MODE_WRITE, OFF_CUR_COUNT, 32'h1234_5678);
      send_word(MODE_WRITE, 12'h000, 32'hFFFF_FFFF);
      send_word(MODE_WRITE, OFF_SPURIOUS, 32'hFFFF_FFFF);
      send_word(MODE_WRITE, OFF_TIMER_ENTRY, 32'hFFFF_FFFF);
      send_word(MODE_READ, OFF_TIMER_ENTRY, 32'd0);
      send_word(MODE_WRITE, OFF_TIMER_ENTRY, 32'h0002_00AB);
      send_word(MODE_WRITE, OFF_DIVIDE, 32'hFFFF_FFFF);
      send_word(MODE_READ, OFF_DIVIDE, 32'd0);
      send_word(MODE_WRITE, OFF_INIT_COUNT, 32'd2);
      repeat (3) send_word(MODE_TICK, 12'h000, 32'd0);
      send_word(MODE_WRITE, OFF_INIT_COUNT, 32'hFFFF_FFFF);
      send_word(MODE_READ, OFF_CUR_COUNT, 32'd0);
      send_word(MODE_WRITE, OFF_INIT_COUNT, 32'd0);
      send_word(MODE_TICK, 12'hFFF, 32'hFFFF_FFFF);
      send_word(MODE_WRITE, OFF_SPURIOUS, 32'h0000_00FF);
      send_word(MODE_WRITE, OFF_INIT_COUNT, 32'd1);
      send_word(MODE_TICK, 12'h000, 32'd0);

      while (items_sent < ITEM_TARGET) begin
         if (!held && items_sent >= 150) begin
            held = 1'b1;
            hold_request = 1'b1;
            steady_left = 30;
         end
         if (!paused && items_sent >= 300) begin
            paused = 1'b1;
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (tracker.pending_results.size() != 0) @(posedge clock);
         end
         if ($urandom_range(0, 9) < 8)
            program_and_run();
         else
            repeat ($urandom_range(1, 6)) noise_word();
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d words: %0d ticks, %0d reads, %0d writes, %0d interrupts",
               items_sent, tracker.ticks, tracker.reads, tracker.writes, tracker.fires);
      $display("checked %0d results, %0d long hold-offs, %0d mismatches",
               tracker.words_checked, holds_done, tracker.errors);
      if (tracker.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
